[rtl/csem_pkg.sv]
// ----------------------------------------------------------------------------
// csem_pkg: shared types and constants of the counting semaphore
// Event codes, command codes, register indexes and the cell control struct.
// ----------------------------------------------------------------------------
`default_nettype none
package csem_pkg;
  localparam int unsigned QueueDepthDef     = 16;
  localparam int unsigned TaskCountDef      = 64;
  localparam int unsigned PriorityLevelsDef = 32;

  localparam logic [1:0] CmdTake   = 2'd0;
  localparam logic [1:0] CmdGive   = 2'd1;
  localparam logic [1:0] CmdExpire = 2'd2;
  localparam logic [1:0] CmdNop    = 2'd3;

  localparam logic [2:0] EvGranted  = 3'd0;
  localparam logic [2:0] EvFailed   = 3'd1;
  localparam logic [2:0] EvQueued   = 3'd2;
  localparam logic [2:0] EvAccepted = 3'd3;
  localparam logic [2:0] EvWoken    = 3'd4;
  localparam logic [2:0] EvIgnored  = 3'd5;
  localparam logic [2:0] EvFull     = 3'd6;

  localparam logic RegCountLimit   = 1'b0;
  localparam logic RegInitialCount = 1'b1;

  typedef struct packed {
    logic [5:0]  task_id;
    logic [4:0]  level;
    logic [15:0] need;
  } entry_t;

  // control broadcast to every cell
  typedef struct packed {
    logic   insert;   // insert new entry at its sorted place
    logic   remove;   // drop entry whose remove flag is set, shift left
    entry_t data;     // entry to insert
  } cell_ctrl_t;
endpackage
`default_nettype wire

[rtl/csem_cell.sv]
// ----------------------------------------------------------------------------
// csem_cell: one slot of the sorted wait queue
// Holds one waiter; shifts right on insert, left on remove.
// ----------------------------------------------------------------------------
`default_nettype none
module csem_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire csem_pkg::cell_ctrl_t ctrl_i,
  input  wire logic              left_valid_i,
  input  wire csem_pkg::entry_t  left_data_i,
  input  wire logic              left_shift_i,   // left neighbour moves right
  input  wire logic              right_valid_i,
  input  wire csem_pkg::entry_t  right_data_i,
  input  wire logic              remove_here_i,  // this or a left cell removed
  output logic                   valid_o,
  output csem_pkg::entry_t       data_o,
  output logic                   shift_o         // this cell moves right
);
  import csem_pkg::*;

  logic   valid_q, valid_d;
  entry_t data_q, data_d;
  logic   later;

  // new entry goes before this one when its level is strictly more urgent
  assign later   = valid_q && (ctrl_i.data.level < data_q.level);
  assign shift_o = ctrl_i.insert && later;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctrl_i.insert) begin
      if (left_shift_i) begin
        valid_d = left_valid_i;
        data_d  = left_data_i;
      end else if (later || (!valid_q && left_valid_i)) begin
        valid_d = 1'b1;
        data_d  = ctrl_i.data;
      end
    end else if (ctrl_i.remove && remove_here_i) begin
      valid_d = right_valid_i;
      data_d  = right_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

[rtl/csem_queue.sv]
// ----------------------------------------------------------------------------
// csem_queue: chain of wait queue cells
// Sorted by level, FIFO within a level; valid entries packed from slot 0.
// ----------------------------------------------------------------------------
`default_nettype none
module csem_queue #(
  parameter int unsigned QueueDepth = csem_pkg::QueueDepthDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire csem_pkg::cell_ctrl_t  ctrl_i,
  input  wire logic [QueueDepth-1:0] remove_sel_i,  // one-hot slot to remove
  output logic [QueueDepth-1:0]      valid_o,
  output csem_pkg::entry_t [QueueDepth-1:0] data_o
);
  import csem_pkg::*;

  logic [QueueDepth-1:0] shift;
  logic [QueueDepth-1:0] rem_pref;

  // slot 0 of the chain sees the new entry on its left as valid
  always_comb begin
    rem_pref[0] = remove_sel_i[0];
    for (int i = 1; i < QueueDepth; i++) begin
      rem_pref[i] = rem_pref[i-1] | remove_sel_i[i];
    end
  end

  for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
    logic   lv, ls, rv;
    entry_t ld, rd;
    if (g == 0) begin : g_first
      assign lv = 1'b1;
      assign ld = ctrl_i.data;
      assign ls = 1'b0;
    end else begin : g_mid
      assign lv = valid_o[g-1];
      assign ld = data_o[g-1];
      assign ls = shift[g-1];
    end
    if (g == QueueDepth - 1) begin : g_last
      assign rv = 1'b0;
      assign rd = data_o[g];
    end else begin : g_inner
      assign rv = valid_o[g+1];
      assign rd = data_o[g+1];
    end
    csem_cell u_cell (
      .clk_i,
      .rst_ni,
      .ctrl_i,
      .left_valid_i  (lv),
      .left_data_i   (ld),
      .left_shift_i  (ls),
      .right_valid_i (rv),
      .right_data_i  (rd),
      .remove_here_i (rem_pref[g]),
      .valid_o       (valid_o[g]),
      .data_o        (data_o[g]),
      .shift_o       (shift[g])
    );
  end

  // queue stays packed from slot 0 and sorted by level
  for (genvar g = 1; g < QueueDepth; g++) begin : g_chk
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      valid_o[g] |-> valid_o[g-1]) else $error("queue not packed");
    assert property (@(posedge clk_i) disable iff (!rst_ni)
      valid_o[g] |-> data_o[g-1].level <= data_o[g].level)
      else $error("queue out of order");
  end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.remove |-> $onehot0(remove_sel_i)) else $error("multiple remove");
endmodule
`default_nettype wire

[rtl/counting_semaphore_wait_queue_top.sv]
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue_top: counting semaphore with priority queue
// Take, give and expire requests against a capped count and a sorted queue.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each result is
// shown for one cycle with valid_o; the receiver cannot stall. Take and
// expire are decided in the decide state, and the edge that leaves it
// registers their one result and frees the block. A give shows its
// accepted result likewise, then one woken result per cycle, each with one
// queue shift, up to QueueDepth of them. The wake pass looks one waiter
// ahead so that last_event_o is set on the final woken result itself. An
// unknown command is taken and gives no result. busy is high from the
// accepting edge to the edge that shows the final result.
// The queue is a chain of cells that shifts one place per insert or removal.
`default_nettype none
module counting_semaphore_wait_queue_top #(
  parameter int unsigned QueueDepth     = csem_pkg::QueueDepthDef,
  parameter int unsigned TaskCount      = csem_pkg::TaskCountDef,
  parameter int unsigned PriorityLevels = csem_pkg::PriorityLevelsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic [1:0]  command_i,
  input  wire logic [5:0]  task_id_i,
  input  wire logic [4:0]  task_priority_i,
  input  wire logic [15:0] amount_i,
  input  wire logic        no_wait_i,
  output logic             valid_o,
  output logic [2:0]       event_kind_o,
  output logic [5:0]       event_task_o,
  output logic [15:0]      event_amount_o,
  output logic             last_event_o
);
  import csem_pkg::*;

  typedef enum logic [1:0] {StIdle, StDecide, StWake} state_e;

  state_e      state_q;
  logic [15:0] limit_q, init_q, count_q;
  logic [1:0]  cmd_q;
  logic [5:0]  task_q;
  logic [4:0]  lvl_q;
  logic [15:0] amt_q;
  logic        nowait_q;

  cell_ctrl_t                    ctrl;
  logic [QueueDepth-1:0]         qvalid, match, rem_sel;
  entry_t [QueueDepth-1:0]       qdata;
  logic [15:0] eff_limit, room, acc;
  logic        task_ok, found, full;

  assign eff_limit = (limit_q == 16'd0) ? 16'd1 : limit_q;
  assign busy      = (state_q != StIdle);

  // clamp the level, limit the task range
  logic [4:0] lvl_in;
  always_comb begin
    lvl_in = task_priority_i;
    if (32'(task_priority_i) >= PriorityLevels) lvl_in = 5'(PriorityLevels - 1);
  end
  assign task_ok = (32'(task_q) < TaskCount);

  for (genvar g = 0; g < QueueDepth; g++) begin : g_m
    assign match[g] = qvalid[g] && (qdata[g].task_id == task_q);
  end
  assign found = task_ok && (match != '0);
  assign full  = qvalid[QueueDepth-1];
  assign room  = eff_limit - count_q;
  assign acc   = (amt_q > room) ? room : amt_q;

  // every match is selected (task ids are unique in the queue anyway); the head in wake
  always_comb begin
    rem_sel = '0;
    if (state_q == StDecide && cmd_q == CmdExpire && found) rem_sel = match;
    else if (state_q == StWake) rem_sel[0] = 1'b1;
  end

  logic wake_ok;
  assign wake_ok = qvalid[0] && (count_q != 16'd0) && (qdata[0].need <= count_q);

  // look ahead: does the head fit after the give, does the next fit after this wake
  logic        next_valid;
  entry_t      next_entry;
  logic [15:0] give_cnt, wake_cnt;
  logic        give_fit, wake_more;
  if (QueueDepth > 1) begin : g_next
    assign next_valid = qvalid[1];
    assign next_entry = qdata[1];
  end else begin : g_no_next
    assign next_valid = 1'b0;
    assign next_entry = '0;
  end
  assign give_cnt  = count_q + acc;
  assign wake_cnt  = count_q - qdata[0].need;
  assign give_fit  = qvalid[0] && (give_cnt != 16'd0) && (qdata[0].need <= give_cnt);
  assign wake_more = next_valid && (wake_cnt != 16'd0) && (next_entry.need <= wake_cnt);

  always_comb begin
    ctrl.insert = 1'b0;
    ctrl.remove = 1'b0;
    ctrl.data   = '{task_id: task_q, level: lvl_q, need: amt_q};
    if (state_q == StDecide && cmd_q == CmdTake && task_ok && !found &&
        count_q < amt_q && !nowait_q && !full) ctrl.insert = 1'b1;
    if (state_q == StDecide && cmd_q == CmdExpire && found) ctrl.remove = 1'b1;
    if (state_q == StWake && wake_ok) ctrl.remove = 1'b1;
  end

  csem_queue #(.QueueDepth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .remove_sel_i(rem_sel),
    .valid_o(qvalid), .data_o(qdata)
  );

  logic [15:0] clamp_init;
  logic [15:0] nlimit, ninit;
  always_comb begin
    nlimit = (cfg_index_i == RegCountLimit) ? cfg_data_i : limit_q;
    ninit  = (cfg_index_i == RegInitialCount) ? cfg_data_i : init_q;
    if (nlimit == 16'd0) nlimit = 16'd1;
    clamp_init = (ninit > nlimit) ? nlimit : ninit;
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q    <= command_i;
      task_q   <= task_id_i;
      lvl_q    <= lvl_in;
      amt_q    <= amount_i;
      nowait_q <= no_wait_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      limit_q        <= 16'd1;
      init_q         <= 16'd0;
      count_q        <= 16'd0;
      valid_o        <= 1'b0;
      event_kind_o   <= EvGranted;
      event_task_o   <= '0;
      event_amount_o <= '0;
      last_event_o   <= 1'b0;
    end else begin
      valid_o      <= 1'b0;
      last_event_o <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_index_i == RegCountLimit) limit_q <= cfg_data_i;
        else init_q <= cfg_data_i;
        count_q <= clamp_init;
      end
      case (state_q)
        StIdle: begin
          if (start) state_q <= (command_i == CmdNop) ? StIdle : StDecide;
        end
        StDecide: begin
          valid_o        <= 1'b1;
          event_task_o   <= task_q;
          event_amount_o <= 16'd0;
          last_event_o   <= 1'b1;
          state_q        <= StIdle;
          case (cmd_q)
            CmdTake: begin
              if (!task_ok || found) event_kind_o <= EvFailed;
              else if (count_q >= amt_q) begin
                event_kind_o   <= EvGranted;
                event_amount_o <= amt_q;
                count_q        <= count_q - amt_q;
              end else if (nowait_q) event_kind_o <= EvFailed;
              else if (full) event_kind_o <= EvFull;
              else event_kind_o <= EvQueued;
            end
            CmdGive: begin
              event_kind_o   <= EvAccepted;
              event_task_o   <= '0;
              event_amount_o <= acc;
              count_q        <= give_cnt;
              last_event_o   <= !give_fit;
              state_q        <= give_fit ? StWake : StIdle;
            end
            default: begin
              event_kind_o <= found ? EvWoken : EvIgnored;
            end
          endcase
        end
        StWake: begin
          // one waiter per cycle; drop back to idle once the next does not fit
          if (wake_ok) begin
            valid_o        <= 1'b1;
            event_kind_o   <= EvWoken;
            event_task_o   <= qdata[0].task_id;
            event_amount_o <= qdata[0].need;
            count_q        <= wake_cnt;
            last_event_o   <= !wake_more;
            if (!wake_more) state_q <= StIdle;
          end else begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

[test/tb_counting_semaphore_wait_queue_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_counting_semaphore_wait_queue_top: self-checking bench of the semaphore
// Drives take, give, expire and unused-command requests with random gaps and checks every
// result event against a cycle-free model of the count and wait queue.
// Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_counting_semaphore_wait_queue_top;
  import csem_pkg::*;

  // command code with no meaning: the block must stay silent
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int unsigned Depth = QueueDepthDef;
  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned SettleCycles = 2 * Depth + 8;

  typedef struct {
    logic [1:0]  cmd;
    logic [5:0]  who;
    logic [4:0]  level;
    logic [15:0] amt;
    logic        nowait;
    int unsigned gap;
  } sem_req_t;

  typedef struct {
    logic [2:0]  kind;
    logic [5:0]  who;
    logic [15:0] amt;
    logic        last;
  } sem_event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic [1:0]  command_i = '0;
  logic [5:0]  task_id_i = '0;
  logic [4:0]  task_priority_i = '0;
  logic [15:0] amount_i = '0;
  logic        no_wait_i = 1'b0;
  logic        valid_o;
  logic [2:0]  event_kind_o;
  logic [5:0]  event_task_o;
  logic [15:0] event_amount_o;
  logic        last_event_o;

  counting_semaphore_wait_queue_top u_top (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .command_i, .task_id_i, .task_priority_i, .amount_i, .no_wait_i,
    .valid_o, .event_kind_o, .event_task_o, .event_amount_o, .last_event_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Semaphore state as the bench believes it
  logic [15:0] limit_reg = 16'd1;
  logic [15:0] initial_reg = 16'd0;
  logic [15:0] sem_count = 16'd0;
  int unsigned waiting = 0;
  logic [5:0]  wait_who [Depth];
  logic [4:0]  wait_level [Depth];
  logic [15:0] wait_need [Depth];

  sem_req_t   pending_reqs [$];
  sem_event_t expected_events [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;

  function automatic logic [15:0] eff_limit();
    return (limit_reg == 16'd0) ? 16'd1 : limit_reg;
  endfunction

  function automatic void reload_count();
    sem_count = (initial_reg > eff_limit()) ? eff_limit() : initial_reg;
  endfunction

  function automatic void push_event(logic [2:0] kind, logic [5:0] who, logic [15:0] amt);
    sem_event_t ev;
    ev.kind = kind;
    ev.who = who;
    ev.amt = amt;
    ev.last = 1'b0;
    expected_events.push_back(ev);
  endfunction

  function automatic int find_waiter(logic [5:0] who);
    for (int i = 0; i < waiting; i++)
      if (wait_who[i] == who) return i;
    return -1;
  endfunction

  function automatic void drop_waiter(int pos);
    for (int i = pos; i + 1 < waiting; i++) begin
      wait_who[i] = wait_who[i+1];
      wait_level[i] = wait_level[i+1];
      wait_need[i] = wait_need[i+1];
    end
    waiting--;
  endfunction

  // Work out the events one accepted request causes and advance the state
  function automatic void semaphore_predict(sem_req_t r);
    int before_cnt;
    int pos;
    logic [15:0] room;
    logic [15:0] acc;
    before_cnt = expected_events.size();
    case (r.cmd)
      CmdTake: begin
        if (find_waiter(r.who) >= 0) push_event(EvFailed, r.who, 16'd0);
        else if (sem_count >= r.amt) begin
          sem_count -= r.amt;
          push_event(EvGranted, r.who, r.amt);
        end else if (r.nowait) push_event(EvFailed, r.who, 16'd0);
        else if (waiting >= Depth) push_event(EvFull, r.who, 16'd0);
        else begin
          // FIFO within a level: go behind every entry of equal or better level
          pos = 0;
          while (pos < waiting && wait_level[pos] <= r.level) pos++;
          for (int i = waiting; i > pos; i--) begin
            wait_who[i] = wait_who[i-1];
            wait_level[i] = wait_level[i-1];
            wait_need[i] = wait_need[i-1];
          end
          wait_who[pos] = r.who;
          wait_level[pos] = r.level;
          wait_need[pos] = r.amt;
          waiting++;
          push_event(EvQueued, r.who, 16'd0);
        end
      end
      CmdGive: begin
        room = eff_limit() - sem_count;
        acc = (r.amt > room) ? room : r.amt;
        sem_count += acc;
        push_event(EvAccepted, 6'd0, acc);
        // wake from the head while it fits; stop at the first that does not
        while (sem_count > 0 && waiting > 0 && wait_need[0] <= sem_count) begin
          sem_count -= wait_need[0];
          push_event(EvWoken, wait_who[0], wait_need[0]);
          drop_waiter(0);
        end
      end
      CmdExpire: begin
        pos = find_waiter(r.who);
        if (pos >= 0) begin
          drop_waiter(pos);
          push_event(EvWoken, r.who, 16'd0);
        end else push_event(EvIgnored, r.who, 16'd0);
      end
      default: ;
    endcase
    if (expected_events.size() > before_cnt)
      expected_events[expected_events.size()-1].last = 1'b1;
  endfunction

  // Driver: hold a request until taken, then advance after its drawn gap
  sem_req_t cur_req;
  sem_req_t next_req;
  logic     have_next = 1'b0;
  int unsigned hold_off = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) semaphore_predict(cur_req);
      if (!(start && busy)) begin
        if (!have_next && pending_reqs.size() > 0) begin
          next_req = pending_reqs.pop_front();
          have_next = 1'b1;
          hold_off = next_req.gap;
        end
        if (have_next && hold_off == 0) begin
          cur_req = next_req;
          have_next = 1'b0;
          start <= 1'b1;
          command_i <= next_req.cmd;
          task_id_i <= next_req.who;
          task_priority_i <= next_req.level;
          amount_i <= next_req.amt;
          no_wait_i <= next_req.nowait;
        end else begin
          if (have_next) hold_off--;
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest expectation
  always @(posedge clk_i) begin
    sem_event_t want;
    if (rst_ni && valid_o) begin
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected event kind=%0d task=%0d amount=%0d last=%0b",
                   event_kind_o, event_task_o, event_amount_o, last_event_o);
      end else begin
        want = expected_events.pop_front();
        if (event_kind_o !== want.kind || event_task_o !== want.who ||
            event_amount_o !== want.amt || last_event_o !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("event mismatch: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                     want.kind, want.who, want.amt, want.last, event_kind_o,
                     event_task_o, event_amount_o, last_event_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL counting_semaphore_wait_queue_top");
      $finish;
    end
  end

  function automatic void add_req(logic [1:0] cmd, logic [5:0] who, logic [4:0] level,
                                  logic [15:0] amt, logic nowait);
    sem_req_t r;
    r.cmd = cmd;
    r.who = who;
    r.level = level;
    r.amt = amt;
    r.nowait = nowait;
    r.gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
    pending_reqs.push_back(r);
  endfunction

  function automatic logic [15:0] draw_amount();
    int unsigned span;
    span = (eff_limit() > 9) ? eff_limit() / 3 + 1 : 4;
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, span));
    endcase
  endfunction

  function automatic void add_random(int unsigned n);
    int unsigned pick;
    logic [5:0] who;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      // mostly a small pool of tasks so duplicates and expiries hit waiters
      who = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 19));
      if (pick < 45)
        add_req(CmdTake, who, 5'($urandom), draw_amount(), $urandom_range(0, 3) == 0);
      else if (pick < 80)
        add_req(CmdGive, 6'($urandom), 5'($urandom), draw_amount(), 1'($urandom));
      else if (pick < 95)
        add_req(CmdExpire, who, 5'($urandom), 16'($urandom), 1'($urandom));
      else
        add_req(CmdUnused, 6'($urandom), 5'($urandom), 16'($urandom), 1'($urandom));
    end
  endfunction

  // Wait until every request is taken and answered, then let the block settle
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || have_next || start || expected_events.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == RegCountLimit) limit_reg = value;
    else initial_reg = value;
    reload_count();
  endtask

  initial begin
    reload_count();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setting: limit 1, count 0
    add_req(CmdTake, 6'd1, 5'd0, 16'd0, 1'b0);       // zero take granted
    add_req(CmdTake, 6'd2, 5'd31, 16'd1, 1'b1);      // no-wait fails
    add_req(CmdTake, 6'd3, 5'd5, 16'd1, 1'b0);
    add_req(CmdTake, 6'd3, 5'd5, 16'd1, 1'b0);       // already waiting
    add_req(CmdTake, 6'd4, 5'd0, 16'd1, 1'b0);       // jumps ahead
    add_req(CmdTake, 6'd5, 5'd5, 16'd1, 1'b0);       // behind task 3
    add_req(CmdExpire, 6'd63, 5'd0, 16'd0, 1'b0);    // task 63 not waiting: ignored
    add_req(CmdExpire, 6'd3, 5'd0, 16'd0, 1'b0);
    add_req(CmdUnused, 6'd7, 5'd7, 16'h5A5A, 1'b1);  // silent
    add_req(CmdGive, 6'd0, 5'd0, 16'd0, 1'b0);       // zero give: accepted only, no wake
    add_req(CmdGive, 6'd0, 5'd0, 16'hFFFF, 1'b0);    // saturates, wakes task 4
    add_req(CmdGive, 6'd0, 5'd0, 16'd1, 1'b0);       // wakes task 5
    // fill the queue, then overflow it
    for (int i = 0; i < Depth; i++)
      add_req(CmdTake, 6'(40 + i), 5'($urandom), 16'd2, 1'b0);
    add_req(CmdTake, 6'd62, 5'd0, 16'hFFFF, 1'b0);   // queue full
    add_req(CmdGive, 6'd0, 5'd0, 16'd1, 1'b0);       // head does not fit
    wait_idle();

    write_reg(RegCountLimit, 16'hFFFF);
    write_reg(RegInitialCount, 16'hFFFF);
    add_random(40);
    wait_idle();

    // zero limit acts as one
    write_reg(RegCountLimit, 16'd0);
    add_random(40);
    wait_idle();

    write_reg(RegCountLimit, 16'd100);
    write_reg(RegInitialCount, 16'd37);
    add_random(40);
    wait_idle();

    write_reg(RegCountLimit, 16'd7);
    write_reg(RegInitialCount, 16'd0);
    add_random(40);
    wait_idle();

    if (mismatches == 0) begin
      $display("PASS counting_semaphore_wait_queue_top");
    end else begin
      $display("FAIL counting_semaphore_wait_queue_top");
    end
    $finish;
  end
endmodule
`default_nettype wire
